@@ rtl/ffta_pkg.sv @@
// Package with the item types, state encoding and constants of the timed first-fit allocator.
package ffta_pkg;

    localparam logic [30:0] MEM_CAP   = 31'h4000_0000;
    localparam logic [30:0] TIME_MAX  = 31'h7FFF_FFFF;
    localparam logic [23:0] COUNT_MAX = 24'hFF_FFFF;

    typedef struct packed {
        logic [29:0] arrival_time;
        logic [30:0] request_size;
        logic [29:0] hold_time;
        logic        flush;
    } t_in_item;

    typedef struct packed {
        logic        placed_now;
        logic [29:0] start_address;
        logic [23:0] waited_total;
        logic [30:0] last_release_time;
        logic        queue_overflow;
        logic        final_res;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIN_SCAN,
        ST_COMPACT,
        ST_RETRY_LOAD,
        ST_FIT_SCAN,
        ST_SHIFT,
        ST_WRITE,
        ST_NEW_LOAD,
        ST_DONE
    } t_state;

endpackage

@@ rtl/first_fit_timed_allocator.sv @@
// Timed first-fit allocator: a block table in address order, release times and a FIFO wait queue.
// The time one item takes depends on the data. Each scan step visits one table entry
// through a registered table read: a release pass is a minimum search over the release
// times, then a compaction sweep that drops the entries at that minimum, then a retry
// load from the head of the wait queue; each retry or new request runs a gap search over
// the entries in address order, then shifts the entries above the chosen slot up by one,
// then writes the new entry, with steps of setup and result around them.
// The block is not ready while an item is in progress; the result waits in an output
// register, and the next item is taken in the cycle after the result is accepted.
module first_fit_timed_allocator #(
    parameter int MAX_BLOCKS = 64,
    parameter int WAIT_DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [30:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ffta_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ffta_pkg::t_out_item  o_out_item
);
    import ffta_pkg::*;

    localparam int BW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int WW = $clog2(WAIT_DEPTH);
    localparam int FW = $clog2(WAIT_DEPTH + 1);
    localparam logic [CW-1:0] BLK_MAX = CW'(MAX_BLOCKS);
    localparam logic [FW-1:0] WQ_MAX  = FW'(WAIT_DEPTH);

    logic [30:0] mem_start [MAX_BLOCKS];
    logic [30:0] mem_len   [MAX_BLOCKS];
    logic [30:0] mem_rel   [MAX_BLOCKS];
    logic [30:0] mem_wsize [WAIT_DEPTH];
    logic [29:0] mem_whold [WAIT_DEPTH];

    t_state      r_state, n_state;
    logic [30:0] r_mem_size;
    logic [CW-1:0] r_count, n_count;
    logic [WW-1:0] r_whead, n_whead;
    logic [FW-1:0] r_wfill, n_wfill;
    logic [23:0] r_waited, n_waited;
    logic [30:0] r_latest, n_latest;
    t_in_item    r_item;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_wr, n_wr;
    logic [30:0] r_min, n_min;
    logic [31:0] r_pos, n_pos;
    logic        r_retry, n_retry;
    logic [30:0] r_size, n_size;
    logic [29:0] r_hold, n_hold;
    logic [30:0] r_now, n_now;

    logic [30:0] r_rd_start, r_rd_len, r_rd_rel;
    logic [30:0] r_rd_wsize;
    logic [29:0] r_rd_whold;
    logic [BW-1:0] rd_addr;

    logic        wr_en;
    logic [BW-1:0] wr_addr;
    logic [30:0] wr_start, wr_len, wr_rel;
    logic        wq_en;

    logic [30:0] lim;
    logic [31:0] cap;
    logic [31:0] gap;
    logic        fits;
    logic [31:0] rel_sum;
    logic [30:0] rel_sat;

    // Table reads are registered; the address follows the next index, or the entry
    // below the shift pointer while entries move up.
    assign rd_addr = (n_state == ST_SHIFT) ? BW'(n_wr - 1'b1) : n_idx[BW-1:0];

    assign lim = (r_mem_size > MEM_CAP) ? MEM_CAP : r_mem_size;
    always_comb begin
        cap = {1'b0, lim};
        if (r_idx < r_count && {1'b0, r_rd_start} < cap) begin
            cap = {1'b0, r_rd_start};
        end
        gap  = cap - r_pos;
        fits = (cap > r_pos) && (gap >= {1'b0, r_size});
    end
    assign rel_sum = {1'b0, r_now} + {2'b0, r_hold};
    assign rel_sat = (rel_sum > {1'b0, TIME_MAX}) ? TIME_MAX : rel_sum[30:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:       if (i_in_valid && !r_out_valid) n_state = ST_MIN_SCAN;
            ST_MIN_SCAN: begin
                if (r_count == '0) begin
                    n_state = r_item.flush ? ST_DONE : ST_NEW_LOAD;
                end else if (r_idx == r_count) begin
                    if (!r_item.flush && r_min > {1'b0, r_item.arrival_time}) begin
                        n_state = ST_NEW_LOAD;
                    end else begin
                        n_state = ST_COMPACT;
                    end
                end
            end
            ST_COMPACT:    if (r_idx == r_count) n_state = ST_RETRY_LOAD;
            ST_RETRY_LOAD: n_state = (r_wfill == '0) ? ST_MIN_SCAN : ST_FIT_SCAN;
            ST_FIT_SCAN: begin
                if (r_count >= BLK_MAX) begin
                    n_state = r_retry ? ST_MIN_SCAN : ST_DONE;
                end else if (fits) begin
                    n_state = ST_SHIFT;
                end else if (r_idx == r_count) begin
                    n_state = r_retry ? ST_MIN_SCAN : ST_DONE;
                end
            end
            ST_SHIFT:      if (r_wr == r_idx) n_state = ST_WRITE;
            ST_WRITE:      n_state = r_retry ? ST_RETRY_LOAD : ST_DONE;
            ST_NEW_LOAD:   n_state = ST_FIT_SCAN;
            ST_DONE:       n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_count     = r_count;
        n_whead     = r_whead;
        n_wfill     = r_wfill;
        n_waited    = r_waited;
        n_latest    = r_latest;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_idx       = r_idx;
        n_wr        = r_wr;
        n_min       = r_min;
        n_pos       = r_pos;
        n_retry     = r_retry;
        n_size      = r_size;
        n_hold      = r_hold;
        n_now       = r_now;
        wr_en       = 1'b0;
        wr_addr     = r_wr[BW-1:0];
        wr_start    = r_rd_start;
        wr_len      = r_rd_len;
        wr_rel      = r_rd_rel;
        wq_en       = 1'b0;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                n_min = TIME_MAX;
                if (!r_out_valid) n_out = '0;
            end
            ST_MIN_SCAN: begin
                if (r_idx < r_count) begin
                    if (r_rd_rel < r_min) n_min = r_rd_rel;
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_idx = '0;
                    n_wr  = '0;
                end
            end
            ST_COMPACT: begin
                if (r_idx < r_count) begin
                    if (r_rd_rel != r_min) begin
                        wr_en = 1'b1;
                        n_wr  = r_wr + 1'b1;
                    end
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_count  = r_wr;
                    n_latest = r_min;
                end
            end
            ST_RETRY_LOAD: begin
                n_idx   = '0;
                n_pos   = '0;
                n_retry = 1'b1;
                n_size  = (r_rd_wsize == '0) ? 31'd1 : r_rd_wsize;
                n_hold  = r_rd_whold;
                n_now   = r_latest;
                n_min   = TIME_MAX;
            end
            ST_NEW_LOAD: begin
                n_idx   = '0;
                n_pos   = '0;
                n_retry = 1'b0;
                n_size  = (r_item.request_size == '0) ? 31'd1 : r_item.request_size;
                n_hold  = r_item.hold_time;
                n_now   = {1'b0, r_item.arrival_time};
            end
            ST_FIT_SCAN: begin
                if (r_count < BLK_MAX && fits) begin
                    n_wr = r_count;
                end else if (r_count >= BLK_MAX || r_idx == r_count) begin
                    n_idx = '0;
                    n_min = TIME_MAX;
                    if (!r_retry) begin
                        if (r_waited < COUNT_MAX) n_waited = r_waited + 1'b1;
                        if (r_wfill >= WQ_MAX) begin
                            n_out.queue_overflow = 1'b1;
                        end else begin
                            wq_en   = 1'b1;
                            n_wfill = r_wfill + 1'b1;
                        end
                    end
                end else begin
                    n_pos = {1'b0, r_rd_start} + {1'b0, r_rd_len};
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_SHIFT: begin
                if (r_wr != r_idx) begin
                    wr_en    = 1'b1;
                    wr_addr  = r_wr[BW-1:0];
                    n_wr     = r_wr - 1'b1;
                end
            end
            ST_WRITE: begin
                wr_en    = 1'b1;
                wr_addr  = r_idx[BW-1:0];
                wr_start = r_pos[30:0];
                wr_len   = r_size;
                wr_rel   = rel_sat;
                n_count  = r_count + 1'b1;
                if (r_retry) begin
                    n_whead = (WAIT_DEPTH & (WAIT_DEPTH - 1)) == 0 ? r_whead + 1'b1
                            : ((r_whead == WW'(WAIT_DEPTH - 1)) ? '0 : r_whead + 1'b1);
                    n_wfill = r_wfill - 1'b1;
                end else begin
                    n_out.placed_now    = 1'b1;
                    n_out.start_address = r_pos[29:0];
                end
            end
            ST_DONE: begin
                n_out.final_res         = r_item.flush;
                n_out.waited_total      = r_waited;
                n_out.last_release_time = r_latest;
                n_out_valid             = 1'b1;
            end
            default: ;
        endcase
    end

    logic [FW:0] wq_sum;
    logic [WW-1:0] wq_slot;
    always_comb begin
        wq_sum  = {1'b0, r_wfill} + (FW+1)'(r_whead);
        wq_slot = (wq_sum >= (FW+1)'(WAIT_DEPTH)) ? WW'(wq_sum - (FW+1)'(WAIT_DEPTH))
                                                   : WW'(wq_sum);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_start[wr_addr] <= wr_start;
            mem_len[wr_addr]   <= wr_len;
            mem_rel[wr_addr]   <= wr_rel;
        end
        if (wq_en) begin
            mem_wsize[wq_slot] <= r_size;
            mem_whold[wq_slot] <= r_hold;
        end
        r_rd_start <= mem_start[rd_addr];
        r_rd_len   <= mem_len[rd_addr];
        r_rd_rel   <= mem_rel[rd_addr];
        r_rd_wsize <= mem_wsize[n_whead];
        r_rd_whold <= mem_whold[n_whead];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mem_size  <= MEM_CAP;
            r_count     <= '0;
            r_whead     <= '0;
            r_wfill     <= '0;
            r_waited    <= '0;
            r_latest    <= '0;
            r_out_valid <= 1'b0;
            r_retry     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_whead     <= n_whead;
            r_wfill     <= n_wfill;
            r_waited    <= n_waited;
            r_latest    <= n_latest;
            r_out_valid <= n_out_valid;
            r_retry     <= n_retry;
            if (i_cfg_valid) r_mem_size <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) r_item <= i_in_item;
        r_out  <= n_out;
        r_idx  <= n_idx;
        r_wr   <= n_wr;
        r_min  <= n_min;
        r_pos  <= n_pos;
        r_size <= n_size;
        r_hold <= n_hold;
        r_now  <= n_now;
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= BLK_MAX) else $error("block count above table size");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wfill <= WQ_MAX) else $error("wait fill above queue depth");
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_state == ST_IDLE) else $error("result shown while busy");
    a_result_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> r_out_valid) else $error("result not raised");
endmodule
